### rtl/core/slpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo line packet reassembler package
// Shared constants, codes and transaction types of the reassembler.
// ----------------------------------------------------------------------------
package slpr_pkg;

	// Geometry of the line store and of the IMU timestamp window.
	localparam int LINES    = 240;
	localparam int WINDOW   = 16;
	localparam int IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W   = $clog2(WINDOW + 1);
	localparam int STAMP_W  = 63;

	// Reset value of the accepted packet length.
	localparam logic [11:0] EXPECTED_LEN_RST = 12'd1294;

	// Packet type codes.
	localparam logic [7:0] KIND_LEFT    = 8'd1;
	localparam logic [7:0] KIND_RIGHT   = 8'd2;
	localparam logic [7:0] KIND_FEATURE = 8'd3;
	localparam logic [7:0] KIND_IMU     = 8'd4;

	// Image packet markers and the feature set range.
	localparam logic [7:0] MARK_START = 8'hAA;
	localparam logic [7:0] MARK_MID   = 8'h00;
	localparam logic [7:0] MARK_END   = 8'hBB;
	localparam logic [7:0] FSET_MIN   = 8'd1;
	localparam logic [7:0] FSET_MAX   = 8'd4;

	// Result action codes.
	localparam logic [2:0] ACT_IGNORE = 3'd0;
	localparam logic [2:0] ACT_LINE   = 3'd1;
	localparam logic [2:0] ACT_DONE   = 3'd2;
	localparam logic [2:0] ACT_SEQ    = 3'd3;
	localparam logic [2:0] ACT_OVER   = 3'd4;
	localparam logic [2:0] ACT_FEAT   = 3'd5;
	localparam logic [2:0] ACT_IMU    = 3'd6;

	// Header fields of one received packet.
	typedef struct packed {
		logic [11:0]        packet_len;
		logic [7:0]         kind;
		logic [7:0]         marker;
		logic [7:0]         count_byte;
		logic [15:0]        seq_image;
		logic [15:0]        seq_feature;
		logic [STAMP_W-1:0] time_stamp;
		logic [STAMP_W-1:0] arrival_time;
	} pkt_hdr_t;

	// Classification result of one packet.
	typedef struct packed {
		logic [2:0]         action;
		logic               eye;
		logic [7:0]         line_index;
		logic               frame_matched;
		logic [STAMP_W-1:0] matched_time;
		logic [2:0]         feature_set;
		logic [7:0]         feature_count;
	} pkt_res_t;

	// One window entry: IMU timestamp and its local arrival time.
	typedef struct packed {
		logic [STAMP_W-1:0] stamp;
		logic [STAMP_W-1:0] arrival;
	} win_entry_t;

	// Append request into the window.
	typedef struct packed {
		logic       en;
		win_entry_t entry;
	} win_wr_t;

	// Search request: start pulse and the frame timestamp to look up.
	typedef struct packed {
		logic               start;
		logic [STAMP_W-1:0] key;
	} srch_req_t;

	// Search response: one-cycle done pulse with the outcome.
	typedef struct packed {
		logic               done;
		logic               hit;
		logic [STAMP_W-1:0] arrival;
	} srch_rsp_t;

endpackage

### rtl/core/slpr_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU timestamp window
// Holds recorded (timestamp, arrival) pairs in a synchronous memory and
// searches them one entry per cycle for a frame timestamp.
// ----------------------------------------------------------------------------
module slpr_window (
	input  logic                 clk,
	input  logic                 arst_n,
	input  slpr_pkg::win_wr_t    wr,
	input  slpr_pkg::srch_req_t  req,
	output slpr_pkg::srch_rsp_t  rsp
);

	slpr_pkg::win_entry_t              mem [slpr_pkg::WINDOW];
	logic [slpr_pkg::FILL_W-1:0]       fill_q;
	logic [slpr_pkg::FILL_W-1:0]       fill_m1;
	logic [slpr_pkg::IDX_W-1:0]        addr_q;
	logic                              issue_q;
	logic                              last_issue;
	logic [slpr_pkg::STAMP_W-1:0]      key_q;
	slpr_pkg::win_entry_t              rdata_s1;
	logic                              rvld_s1;
	logic                              rlast_s1;
	logic                              hit;
	logic                              scan_end;
	slpr_pkg::srch_rsp_t               rsp_q;

	// The fill count is stable during a search, since no packet is taken then.
	assign fill_m1    = fill_q - slpr_pkg::FILL_W'(1);
	assign last_issue = (slpr_pkg::FILL_W'(addr_q) == fill_m1);
	assign hit        = rvld_s1 && (rdata_s1.stamp == key_q);
	assign scan_end   = hit || (rvld_s1 && rlast_s1);
	assign rsp        = rsp_q;

	// Memory write at the fill position and registered read at the scan address.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[fill_q[slpr_pkg::IDX_W-1:0]] <= wr.entry;
		end
		rdata_s1 <= mem[addr_q];
		rlast_s1 <= last_issue;
	end

	// Fill count: the window empties once the last entry is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (wr.en) begin
			if (fill_q == slpr_pkg::FILL_W'(slpr_pkg::WINDOW - 1)) begin
				fill_q <= '0;
			end else begin
				fill_q <= fill_q + slpr_pkg::FILL_W'(1);
			end
		end
	end

	// Scan control: issue reads in order, compare each read entry in the next cycle, stop at
	// the first match or after the last filled entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			addr_q  <= '0;
			key_q   <= '0;
			rvld_s1 <= 1'b0;
			rsp_q   <= '0;
		end else begin
			rvld_s1 <= issue_q && !scan_end;
			if (req.start) begin
				key_q   <= req.key;
				addr_q  <= '0;
				issue_q <= (fill_q != '0);
			end else if (scan_end || (issue_q && last_issue)) begin
				issue_q <= 1'b0;
			end else if (issue_q) begin
				addr_q <= addr_q + slpr_pkg::IDX_W'(1);
			end
			// An empty window answers at once; otherwise the scan answers.
			if (req.start && (fill_q == '0)) begin
				rsp_q.done    <= 1'b1;
				rsp_q.hit     <= 1'b0;
				rsp_q.arrival <= '0;
			end else if (scan_end) begin
				rsp_q.done    <= 1'b1;
				rsp_q.hit     <= hit;
				rsp_q.arrival <= hit ? rdata_s1.arrival : '0;
			end else begin
				rsp_q.done <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/stereo_line_packet_reassembler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo line packet reassembler
// Classifies received packet headers, tracks image lines and frame sequence,
// and looks up finished frames in a window of recorded IMU timestamps.
// ----------------------------------------------------------------------------
// Results: registered; an end packet that completes a frame gets its result
// after the window scan, which compares one entry a cycle.
// Throughput: one packet per cycle outside frame completion while tx_stall
// does not hold a pending result; a completing end packet holds the input
// until its scan result is registered.
// Reset: asynchronous, clears all control state and the window fill count.
module stereo_line_packet_reassembler_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  slpr_pkg::pkt_hdr_t rx_item,
	output logic               tx_valid,
	input  logic               tx_stall,
	output slpr_pkg::pkt_res_t tx_item,
	input  logic               cfg_wr_en,
	input  logic [11:0]        cfg_wr_data
);

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t                        state_q;
	logic [11:0]                   expected_len_q;
	logic [15:0]                   frame_seq_q;
	logic [7:0]                    left_line_q;
	logic [7:0]                    right_line_q;
	logic [slpr_pkg::STAMP_W-1:0]  left_stamp_q;
	logic [slpr_pkg::STAMP_W-1:0]  right_stamp_q;
	logic                          tx_valid_q;
	slpr_pkg::pkt_res_t            tx_item_q;

	logic                          accept;
	logic                          is_image;
	logic                          eye;
	logic                          is_start;
	logic                          is_mid;
	logic                          is_end;
	logic                          seq_ok;
	logic [7:0]                    cur_line;
	logic                          line_over;
	logic                          need_search;
	logic                          line_upd;
	logic [7:0]                    line_next;
	slpr_pkg::pkt_res_t            res;
	slpr_pkg::win_wr_t             win_wr;
	slpr_pkg::srch_req_t           srch_req;
	slpr_pkg::srch_rsp_t           srch_rsp;

	assign tx_valid = tx_valid_q;
	assign tx_item  = tx_item_q;
	assign rx_stall = (state_q != ST_IDLE) || (tx_valid_q && tx_stall);
	assign accept   = rx_valid && !rx_stall;

	// Image packet decode shared by both eyes.
	assign eye       = (rx_item.kind == slpr_pkg::KIND_RIGHT);
	assign is_image  = (rx_item.kind == slpr_pkg::KIND_LEFT) || eye;
	assign is_start  = (rx_item.marker == slpr_pkg::MARK_START);
	assign is_mid    = (rx_item.marker == slpr_pkg::MARK_MID);
	assign is_end    = (rx_item.marker == slpr_pkg::MARK_END);
	assign seq_ok    = (is_start && !eye) || (rx_item.seq_image == frame_seq_q);
	assign cur_line  = eye ? right_line_q : left_line_q;
	assign line_over = (cur_line >= 8'(slpr_pkg::LINES));

	// Classification of one packet and the line counter update it causes.
	always_comb begin
		res         = '0;
		res.action  = slpr_pkg::ACT_IGNORE;
		need_search = 1'b0;
		line_upd    = 1'b0;
		line_next   = '0;
		win_wr      = '0;
		if (rx_item.packet_len == expected_len_q) begin
			if (is_image && (is_start || is_mid || is_end)) begin
				res.eye = eye;
				if (!seq_ok) begin
					res.action = slpr_pkg::ACT_SEQ;
				end else if (is_start) begin
					res.action = slpr_pkg::ACT_LINE;
					line_upd   = 1'b1;
					line_next  = 8'd1;
				end else if (line_over) begin
					res.action = slpr_pkg::ACT_OVER;
					line_upd   = 1'b1;
				end else if (is_mid) begin
					res.action     = slpr_pkg::ACT_LINE;
					res.line_index = cur_line;
					line_upd       = 1'b1;
					line_next      = cur_line + 8'd1;
				end else begin
					res.action     = slpr_pkg::ACT_DONE;
					res.line_index = cur_line;
					line_upd       = 1'b1;
					need_search    = 1'b1;
				end
			end else if (rx_item.kind == slpr_pkg::KIND_FEATURE) begin
				if ((rx_item.marker >= slpr_pkg::FSET_MIN) &&
				    (rx_item.marker <= slpr_pkg::FSET_MAX)) begin
					if (rx_item.seq_feature != frame_seq_q) begin
						res.action = slpr_pkg::ACT_SEQ;
					end else begin
						res.action        = slpr_pkg::ACT_FEAT;
						res.feature_set   = rx_item.marker[2:0];
						res.feature_count = rx_item.count_byte;
					end
				end
			end else if (rx_item.kind == slpr_pkg::KIND_IMU) begin
				res.action          = slpr_pkg::ACT_IMU;
				win_wr.en           = accept;
				win_wr.entry.stamp   = rx_item.time_stamp;
				win_wr.entry.arrival = rx_item.arrival_time;
			end
		end
	end

	// Frame completion hands the frame timestamp to the window scan.
	assign srch_req.start = accept && need_search;
	assign srch_req.key   = eye ? right_stamp_q : left_stamp_q;

	slpr_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (win_wr),
		.req    (srch_req),
		.rsp    (srch_rsp)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_len_q <= slpr_pkg::EXPECTED_LEN_RST;
		end else if (cfg_wr_en) begin
			expected_len_q <= cfg_wr_data;
		end
	end

	// Frame context: sequence number, line counters and frame timestamps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_seq_q   <= '0;
			left_line_q   <= '0;
			right_line_q  <= '0;
			left_stamp_q  <= '0;
			right_stamp_q <= '0;
		end else if (accept && line_upd) begin
			if (eye) begin
				right_line_q <= line_next;
			end else begin
				left_line_q <= line_next;
			end
			if (is_start) begin
				if (eye) begin
					right_stamp_q <= rx_item.time_stamp;
				end else begin
					left_stamp_q <= rx_item.time_stamp;
					frame_seq_q  <= rx_item.seq_image;
				end
			end
		end
	end

	// Control state and the registered result transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tx_valid_q <= 1'b0;
			tx_item_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						tx_item_q <= res;
						if (need_search) begin
							state_q    <= ST_SEARCH;
							tx_valid_q <= 1'b0;
						end else begin
							tx_valid_q <= 1'b1;
						end
					end else if (!tx_stall) begin
						tx_valid_q <= 1'b0;
					end
				end
				ST_SEARCH: begin
					if (srch_rsp.done) begin
						tx_item_q.frame_matched <= srch_rsp.hit;
						tx_item_q.matched_time  <= srch_rsp.arrival;
						tx_valid_q              <= 1'b1;
						state_q                 <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### tb/stereo_line_packet_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo line packet reassembler checker
// Watches the packet and result channels and the length register port, keeps
// its own copy of the line, sequence and IMU window state, predicts the
// classification of every accepted packet and compares each result with it.
// ----------------------------------------------------------------------------
module stereo_line_packet_checker
	import slpr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rx_valid,
	input  logic        rx_stall,
	input  pkt_hdr_t    rx_item,
	input  logic        tx_valid,
	input  logic        tx_stall,
	input  pkt_res_t    tx_item,
	input  logic        cfg_wr_en,
	input  logic [11:0] cfg_wr_data,
	output int          fail_count,
	output int          pending
);

	// Mirror of the block state.
	logic [11:0]        accept_len;
	logic [15:0]        cur_seq;
	logic [7:0]         eye_row [2];
	logic [STAMP_W-1:0] eye_stamp [2];
	logic [STAMP_W-1:0] win_stamp [WINDOW];
	logic [STAMP_W-1:0] win_arrival [WINDOW];
	logic [FILL_W-1:0]  win_fill;

	// Results predicted for accepted packets, oldest first.
	pkt_res_t predicted_results [$];
	pkt_res_t want;

	// Classify one packet header and update the mirrored state.
	function automatic pkt_res_t classify_packet(pkt_hdr_t h);
		pkt_res_t   r;
		logic       sel;
		logic [7:0] row;
		int         i;
		r = '0;
		r.action = ACT_IGNORE;
		if (h.packet_len != accept_len)
			return r;
		case (h.kind)
			KIND_LEFT, KIND_RIGHT: begin
				sel = (h.kind == KIND_RIGHT);
				if (h.marker != MARK_START && h.marker != MARK_MID && h.marker != MARK_END)
					return r;
				r.eye = sel;
				// The left start packet defines the frame sequence number.
				if (h.marker == MARK_START && !sel) begin
					cur_seq = h.seq_image;
				end else if (h.seq_image != cur_seq) begin
					r.action = ACT_SEQ;
					return r;
				end
				if (h.marker == MARK_START) begin
					eye_stamp[sel] = h.time_stamp;
					eye_row[sel] = 8'd1;
					r.action = ACT_LINE;
					return r;
				end
				row = eye_row[sel];
				// Past the last row of the line store.
				if (row >= LINES) begin
					eye_row[sel] = 8'd0;
					r.action = ACT_OVER;
					return r;
				end
				r.line_index = row;
				if (h.marker == MARK_MID) begin
					eye_row[sel] = row + 8'd1;
					r.action = ACT_LINE;
					return r;
				end
				// End of frame: look up the frame timestamp in the window.
				eye_row[sel] = 8'd0;
				r.action = ACT_DONE;
				for (i = 0; i < win_fill; i++) begin
					if (win_stamp[i] == eye_stamp[sel]) begin
						r.frame_matched = 1'b1;
						r.matched_time = win_arrival[i];
						break;
					end
				end
			end
			KIND_FEATURE: begin
				if (h.marker >= FSET_MIN && h.marker <= FSET_MAX) begin
					if (h.seq_feature != cur_seq) begin
						r.action = ACT_SEQ;
					end else begin
						r.action = ACT_FEAT;
						r.feature_set = h.marker[2:0];
						r.feature_count = h.count_byte;
					end
				end
			end
			KIND_IMU: begin
				if (win_fill < WINDOW) begin
					win_stamp[win_fill] = h.time_stamp;
					win_arrival[win_fill] = h.arrival_time;
					win_fill = win_fill + 1'b1;
				end
				// A full window is emptied right away.
				if (win_fill >= WINDOW)
					win_fill = '0;
				r.action = ACT_IMU;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Predict on accepted packets, compare on accepted results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_len = EXPECTED_LEN_RST;
			cur_seq = '0;
			eye_row[0] = '0;
			eye_row[1] = '0;
			eye_stamp[0] = '0;
			eye_stamp[1] = '0;
			win_fill = '0;
			predicted_results.delete();
		end else begin
			if (rx_valid && !rx_stall)
				predicted_results.insert(predicted_results.size(),
					classify_packet(rx_item));
			if (tx_valid && !tx_stall) begin
				if (predicted_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result transaction with nothing predicted: action=%0d",
							tx_item.action);
				end else begin
					want = predicted_results.pop_front();
					if (tx_item.action !== want.action || tx_item.eye !== want.eye ||
						tx_item.line_index !== want.line_index ||
						tx_item.frame_matched !== want.frame_matched ||
						tx_item.matched_time !== want.matched_time ||
						tx_item.feature_set !== want.feature_set ||
						tx_item.feature_count !== want.feature_count) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("exp act=%0d eye=%0d row=%0d hit=%0d t=%0h set=%0d n=%0d",
								want.action, want.eye, want.line_index, want.frame_matched,
								want.matched_time, want.feature_set, want.feature_count);
							$display("got act=%0d eye=%0d row=%0d hit=%0d t=%0h set=%0d n=%0d",
								tx_item.action, tx_item.eye, tx_item.line_index,
								tx_item.frame_matched, tx_item.matched_time,
								tx_item.feature_set, tx_item.feature_count);
						end
					end
				end
			end
			if (cfg_wr_en)
				accept_len = cfg_wr_data;
		end
		pending = predicted_results.size();
	end

endmodule

### tb/stereo_line_packet_reassembler_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo line packet reassembler testbench
// Drives directed and random packet headers (well-formed stereo frames with
// features and IMU packets, mixed with broken and noise packets) through the
// block under several packet lengths and idling patterns, and reports the
// verdict of the checker that runs beside the block.
// ----------------------------------------------------------------------------
module stereo_line_packet_reassembler_unit_test;
	import slpr_pkg::*;

	localparam logic [STAMP_W-1:0] STAMP_ONES = {STAMP_W{1'b1}};
	localparam logic [7:0] KIND_UNUSED_LO = 8'd0;
	localparam logic [7:0] KIND_UNUSED_HI = 8'hFF;
	localparam logic [7:0] MARK_UNUSED = 8'h55;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = WINDOW + 8;
	localparam int PHASE_ITEMS = 20;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        rx_valid = 1'b0;
	logic        rx_stall;
	pkt_hdr_t    rx_item = '0;
	logic        tx_valid;
	logic        tx_stall = 1'b0;
	pkt_res_t    tx_item;
	logic        cfg_wr_en = 1'b0;
	logic [11:0] cfg_wr_data = '0;
	int          fail_count;
	int          pending;

	idle_mode_t         idle_mode = IDLE_NONE;
	logic               hold_req = 1'b0;
	logic               hold_ack = 1'b0;
	int                 hold_cnt = 0;
	logic [11:0]        cur_len = EXPECTED_LEN_RST;
	int                 sent_count = 0;
	logic [15:0]        last_seq = '0;
	logic [STAMP_W-1:0] stamp_pool [8];

	stereo_line_packet_reassembler_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_stall    (rx_stall),
		.rx_item     (rx_item),
		.tx_valid    (tx_valid),
		.tx_stall    (tx_stall),
		.tx_item     (tx_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	stereo_line_packet_checker u_classify_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_stall    (rx_stall),
		.rx_item     (rx_item),
		.tx_valid    (tx_valid),
		.tx_stall    (tx_stall),
		.tx_item     (tx_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// Clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int send_idle_pct();
		case (idle_mode)
			IDLE_SEND: return 46;
			IDLE_BOTH: return 35;
			default:   return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct();
		case (idle_mode)
			IDLE_RECV: return 46;
			IDLE_BOTH: return 35;
			default:   return 0;
		endcase
	endfunction

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cnt <= LONG_HOLD - 1;
			tx_stall <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			tx_stall <= 1'b1;
		end else begin
			tx_stall <= ($urandom_range(99) < recv_stall_pct());
		end
	end

	function automatic logic [STAMP_W-1:0] rand63();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[STAMP_W-1:0];
	endfunction

	// Header with the accepted length, the IMU kind and random content in every other field.
	function automatic pkt_hdr_t base_hdr();
		pkt_hdr_t h;
		h.packet_len = cur_len;
		h.kind = KIND_IMU;
		h.marker = 8'($urandom_range(255));
		h.count_byte = 8'($urandom_range(255));
		h.seq_image = 16'($urandom_range(65535));
		h.seq_feature = 16'($urandom_range(65535));
		h.time_stamp = rand63();
		h.arrival_time = rand63();
		return h;
	endfunction

	// Mostly the given sequence number, now and then a wrong one.
	function automatic logic [15:0] bent_seq(logic [15:0] s);
		logic [15:0] flip;
		flip = 16'($urandom_range(1, 65535));
		return ($urandom_range(9) == 0) ? (s ^ flip) : s;
	endfunction

	// One packet transaction; returns right after the accepting edge.
	task automatic send_packet(pkt_hdr_t h);
		while ($urandom_range(99) < send_idle_pct()) begin
			rx_valid <= 1'b0;
			@(posedge clk);
		end
		rx_valid <= 1'b1;
		rx_item <= h;
		sent_count++;
		@(posedge clk);
		while (rx_stall)
			@(posedge clk);
	endtask

	task automatic image_packet(logic [7:0] kind, logic [7:0] marker, logic [15:0] seq,
		logic [STAMP_W-1:0] stamp);
		pkt_hdr_t h;
		h = base_hdr();
		h.kind = kind;
		h.marker = marker;
		h.seq_image = seq;
		h.time_stamp = stamp;
		send_packet(h);
	endtask

	task automatic feature_packet(logic [7:0] fset, logic [15:0] seq, logic [7:0] count);
		pkt_hdr_t h;
		h = base_hdr();
		h.kind = KIND_FEATURE;
		h.marker = fset;
		h.seq_feature = seq;
		h.count_byte = count;
		send_packet(h);
	endtask

	task automatic imu_packet(logic [STAMP_W-1:0] stamp, logic [STAMP_W-1:0] arrival);
		pkt_hdr_t h;
		h = base_hdr();
		h.kind = KIND_IMU;
		h.time_stamp = stamp;
		h.arrival_time = arrival;
		send_packet(h);
	endtask

	// Any kind, any marker, and often a wrong length.
	task automatic noise_packet();
		pkt_hdr_t h;
		h = base_hdr();
		h.packet_len = ($urandom_range(1) == 0) ? cur_len : 12'($urandom_range(2048));
		h.kind = 8'($urandom_range(255));
		send_packet(h);
	endtask

	// Let the block go idle, then write the length and switch idling.
	task automatic configure(logic [11:0] len, idle_mode_t mode);
		rx_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= len;
		idle_mode <= mode;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_len = len;
	endtask

	// A short stereo frame with features, IMU packets and some broken items.
	task automatic run_short_frame();
		logic [15:0]        seq;
		logic [STAMP_W-1:0] ls;
		logic [STAMP_W-1:0] rs;
		logic [STAMP_W-1:0] st;
		int                 steps;
		int                 w;
		seq = ($urandom_range(3) == 0) ? last_seq : 16'($urandom_range(65535));
		last_seq = seq;
		if ($urandom_range(3) == 0)
			stamp_pool[$urandom_range(7)] = rand63();
		ls = stamp_pool[$urandom_range(7)];
		rs = stamp_pool[$urandom_range(7)];
		steps = $urandom_range(2, 12);
		image_packet(KIND_LEFT, MARK_START, seq, ls);
		image_packet(KIND_RIGHT, MARK_START, bent_seq(seq), rs);
		repeat (steps) begin
			w = $urandom_range(99);
			if (w < 30) begin
				image_packet(KIND_LEFT, MARK_MID, bent_seq(seq), rand63());
			end else if (w < 60) begin
				image_packet(KIND_RIGHT, MARK_MID, bent_seq(seq), rand63());
			end else if (w < 72) begin
				feature_packet(8'($urandom_range(FSET_MIN, FSET_MAX)), bent_seq(seq),
					8'($urandom_range(255)));
			end else if (w < 90) begin
				case ($urandom_range(3))
					0:       st = ls;
					1:       st = rs;
					2:       st = stamp_pool[$urandom_range(7)];
					default: st = rand63();
				endcase
				imu_packet(st, rand63());
			end else begin
				noise_packet();
			end
		end
		if ($urandom_range(1) == 0) begin
			image_packet(KIND_LEFT, MARK_END, bent_seq(seq), rand63());
			image_packet(KIND_RIGHT, MARK_END, bent_seq(seq), rand63());
		end else begin
			image_packet(KIND_RIGHT, MARK_END, bent_seq(seq), rand63());
			image_packet(KIND_LEFT, MARK_END, bent_seq(seq), rand63());
		end
	endtask

	task automatic run_frames(int count);
		int first;
		first = sent_count;
		while (sent_count - first < count)
			run_short_frame();
	endtask

	// Full-height frame: the left eye runs past the last row on a middle
	// packet, the right eye on its end packet.
	task automatic run_long_frame();
		logic [15:0]        seq;
		logic [STAMP_W-1:0] ls;
		int                 k;
		seq = 16'($urandom_range(65535));
		ls = rand63();
		image_packet(KIND_LEFT, MARK_START, seq, ls);
		image_packet(KIND_RIGHT, MARK_START, seq, rand63());
		imu_packet(ls, rand63());
		for (k = 0; k < LINES; k++) begin
			image_packet(KIND_LEFT, MARK_MID, seq, rand63());
			if (k < LINES - 1)
				image_packet(KIND_RIGHT, MARK_MID, seq, rand63());
			else
				image_packet(KIND_RIGHT, MARK_END, seq, rand63());
			if (k % 20 == 0)
				feature_packet(8'($urandom_range(FSET_MIN, FSET_MAX)), seq,
					8'($urandom_range(255)));
		end
		image_packet(KIND_LEFT, MARK_END, seq, rand63());
	endtask

	// Stimulus and verdict.
	initial begin
		pkt_hdr_t h;
		stamp_pool[0] = '0;
		stamp_pool[1] = STAMP_ONES;
		for (int i = 2; i < 8; i++)
			stamp_pool[i] = rand63();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		configure(EXPECTED_LEN_RST, IDLE_NONE);

		// Directed: wrong lengths, unknown kinds and markers, sequence checks,
		// start restart, feature set limits, window hits and misses.
		h = base_hdr();
		h.packet_len = 12'd0;
		h.kind = KIND_LEFT;
		h.marker = MARK_START;
		send_packet(h);
		h = base_hdr();
		h.packet_len = 12'd2048;
		send_packet(h);
		image_packet(KIND_LEFT, MARK_MID, 16'h0000, rand63());
		image_packet(KIND_LEFT, MARK_START, 16'hFFFF, STAMP_ONES);
		image_packet(KIND_RIGHT, MARK_START, 16'h1234, '0);
		image_packet(KIND_RIGHT, MARK_START, 16'hFFFF, '0);
		image_packet(KIND_LEFT, MARK_MID, 16'hFFFF, rand63());
		image_packet(KIND_LEFT, MARK_UNUSED, 16'hFFFF, rand63());
		image_packet(KIND_RIGHT, 8'hFF, 16'hFFFF, rand63());
		h = base_hdr();
		h.kind = KIND_UNUSED_LO;
		send_packet(h);
		h = base_hdr();
		h.kind = KIND_UNUSED_HI;
		send_packet(h);
		feature_packet(FSET_MIN - 8'd1, 16'hFFFF, 8'd9);
		feature_packet(FSET_MAX + 8'd1, 16'hFFFF, 8'd9);
		feature_packet(FSET_MIN, 16'hFFFF, 8'd255);
		feature_packet(FSET_MAX, 16'hFFFF, 8'd0);
		feature_packet(8'd2, 16'h0000, 8'd7);
		imu_packet(STAMP_ONES, STAMP_ONES);
		imu_packet('0, 63'h123);
		image_packet(KIND_LEFT, MARK_END, 16'h0000, rand63());
		image_packet(KIND_LEFT, MARK_END, 16'hFFFF, rand63());
		image_packet(KIND_RIGHT, MARK_END, 16'hFFFF, rand63());
		image_packet(KIND_RIGHT, MARK_END, 16'hFFFF, rand63());
		image_packet(KIND_LEFT, MARK_START, 16'hFFFF, 63'd5);
		image_packet(KIND_LEFT, MARK_END, 16'hFFFF, rand63());

		// Random frames under several lengths and idling patterns.
		configure(EXPECTED_LEN_RST, IDLE_NONE);
		run_frames(PHASE_ITEMS);
		configure(12'd0, IDLE_SEND);
		run_frames(PHASE_ITEMS);
		configure(12'd2048, IDLE_RECV);
		run_frames(PHASE_ITEMS);
		configure(12'($urandom_range(2048)), IDLE_BOTH);
		run_frames(PHASE_ITEMS);

		// Long receiver hold-off while the sender keeps offering packets.
		configure(EXPECTED_LEN_RST, IDLE_NONE);
		hold_req <= ~hold_req;
		run_long_frame();

		configure(12'($urandom_range(2048)), IDLE_BOTH);
		run_frames(PHASE_ITEMS);

		// Wait for the last results and a quiet tail.
		rx_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("stereo_line_packet_reassembler_unit verification clean");
		else
			$display("stereo_line_packet_reassembler_unit verification failed");
		$finish;
	end

	// Run limit far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("stereo_line_packet_reassembler_unit verification failed");
		$finish;
	end

endmodule
